@@ rtl/mcr_pkg.sv @@
// Shared constants and types for the midpoint circle rasterizer.
`default_nettype none
package mcr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PIX_PER_POINT  = 8;

    // decision variable terms
    localparam int DEC_INIT       = 3;
    localparam int DEC_INC_STRAIGHT = 6;
    localparam int DEC_INC_DIAG   = 10;

    typedef enum logic {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

endpackage
`default_nettype wire

@@ rtl/mcr_ifs.sv @@
// Valid/ready channel interfaces: command words in, pixel words out.
`default_nettype none
interface mcr_in_if #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-2:0] radius;

    modport source (output valid, kind, center_x, center_y, radius, input ready);
    modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface mcr_pix_if #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] pixel_x;
    logic signed [COORD_BITS+1:0] pixel_y;
    logic                         last_of_point;
    logic                         circle_done;

    modport source (output valid, pixel_x, pixel_y, last_of_point, circle_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_of_point, circle_done, output ready);
endinterface
`default_nettype wire

@@ rtl/mcr_front.sv @@
// Front end: takes command words, runs the midpoint step, queues at most one point per word.
`default_nettype none
module mcr_front #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
    parameter int PT_W       = 4 * COORD_BITS + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcr_in_if.sink          i_in,
    output logic            o_pt_valid,
    input  logic            i_pt_ready,
    output logic [PT_W-1:0] o_pt_data
);
    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 4;

    logic [C-1:0] r_step_x;
    logic [C-1:0] r_step_y;
    logic [D-1:0] r_decision;
    logic [C-1:0] r_origin_x;
    logic [C-1:0] r_origin_y;
    logic         r_running;

    logic [C-1:0] n_step_x;
    logic [C-1:0] n_step_y;
    logic [D-1:0] n_decision;
    logic [D-1:0] start_decision;
    logic [D-1:0] x_ext;
    logic [D-1:0] y_ext;
    logic [D-1:0] inc_straight;
    logic [D-1:0] inc_diag;
    logic         x_gt_y;
    logic         n_gt;
    logic         d_neg;
    logic         can_step;
    logic         is_start;
    logic         accept;

    always_comb begin
        x_ext        = {4'b0, r_step_x};
        y_ext        = {{4{r_step_y[C-1]}}, r_step_y};
        inc_straight = (x_ext << 2) + D'(mcr_pkg::DEC_INC_STRAIGHT);
        inc_diag     = ((x_ext - y_ext) << 2) + D'(mcr_pkg::DEC_INC_DIAG);
        d_neg        = r_decision[D-1];
        x_gt_y       = r_step_y[C-1] ? 1'b1 : (r_step_x > r_step_y);
        can_step     = r_running && !x_gt_y;
        n_step_x     = r_step_x + C'(1);
        n_step_y     = d_neg ? r_step_y : r_step_y - C'(1);
        n_decision   = r_decision + (d_neg ? inc_straight : inc_diag);
        n_gt         = n_step_y[C-1] ? 1'b1 : (n_step_x > n_step_y);
        start_decision = D'(mcr_pkg::DEC_INIT) - {4'b0, i_in.radius, 1'b0};
        is_start     = (i_in.kind == mcr_pkg::KIND_START);
    end

    assign i_in.ready = i_pt_ready;
    assign accept     = i_in.valid && i_pt_ready;
    assign o_pt_valid = i_in.valid && (is_start || can_step);

    always_comb begin
        if (is_start) begin
            o_pt_data = {i_in.center_x, i_in.center_y, C'(0), {1'b0, i_in.radius}, 1'b0};
        end else begin
            o_pt_data = {r_origin_x, r_origin_y, n_step_x, n_step_y, n_gt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x   <= '0;
            r_step_y   <= '0;
            r_decision <= '0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_running  <= 1'b0;
        end else if (accept) begin
            if (is_start) begin
                r_origin_x <= i_in.center_x;
                r_origin_y <= i_in.center_y;
                r_step_x   <= '0;
                r_step_y   <= {1'b0, i_in.radius};
                r_decision <= start_decision;
                r_running  <= 1'b1;
            end else if (can_step) begin
                r_step_x   <= n_step_x;
                r_step_y   <= n_step_y;
                r_decision <= n_decision;
                r_running  <= !n_gt;
            end else begin
                r_running  <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/mcr_queue.sv @@
// Small register queue of points between front and back end.
`default_nettype none
module mcr_queue #(
    parameter int DATA_W = 41,
    parameter int DEPTH  = mcr_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/mcr_back.sv @@
// Back end: expands one queued point into its eight mirrored pixels.
`default_nettype none
module mcr_back #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
    parameter int PT_W       = 4 * COORD_BITS + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pt_valid,
    output logic            o_pt_ready,
    input  logic [PT_W-1:0] i_pt_data,
    mcr_pix_if.source       o_pix
);
    localparam int C     = COORD_BITS;
    localparam int P     = COORD_BITS + 2;
    localparam int IDX_W = $clog2(mcr_pkg::PIX_PER_POINT);

    logic [PT_W-1:0]  r_pt;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [P-1:0]     r_pix_x;
    logic [P-1:0]     r_pix_y;
    logic             r_last;
    logic             r_done;
    logic             r_ovalid;

    logic [C-1:0] cx;
    logic [C-1:0] cy;
    logic [C-1:0] px;
    logic [C-1:0] py;
    logic         pt_done;
    logic [P-1:0] x_ext;
    logic [P-1:0] y_ext;
    logic [P-1:0] off_a;
    logic [P-1:0] off_b;
    logic [P-1:0] n_pix_x;
    logic [P-1:0] n_pix_y;
    logic         swap;
    logic         neg_a;
    logic         neg_b;
    logic         idx_last;
    logic         load_pix;
    logic         fetch;

    assign {cx, cy, px, py, pt_done} = r_pt;

    always_comb begin
        x_ext    = {2'b0, px};
        y_ext    = {{2{py[C-1]}}, py};
        // pixel order: first four use (x, y), last four swap to (y, x)
        swap     = r_idx[2];
        neg_a    = r_idx[1];
        neg_b    = r_idx[2] ? (r_idx[0] ^ r_idx[1]) : !r_idx[0];
        off_a    = swap ? y_ext : x_ext;
        off_b    = swap ? x_ext : y_ext;
        n_pix_x  = {2'b0, cx} + (neg_a ? (P'(0) - off_a) : off_a);
        n_pix_y  = {2'b0, cy} + (neg_b ? (P'(0) - off_b) : off_b);
        idx_last = (r_idx == IDX_W'(mcr_pkg::PIX_PER_POINT - 1));
        load_pix = r_busy && (!r_ovalid || o_pix.ready);
        fetch    = i_pt_valid && (!r_busy || (load_pix && idx_last));
    end

    assign o_pt_ready          = fetch;
    assign o_pix.valid         = r_ovalid;
    assign o_pix.pixel_x       = r_pix_x;
    assign o_pix.pixel_y       = r_pix_y;
    assign o_pix.last_of_point = r_last;
    assign o_pix.circle_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_pt <= i_pt_data;
        end
        if (load_pix) begin
            r_pix_x <= n_pix_x;
            r_pix_y <= n_pix_y;
            r_last  <= idx_last;
            r_done  <= pt_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_pix) begin
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
            if (fetch) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (load_pix) begin
                r_idx <= r_idx + IDX_W'(1);
                if (idx_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/midpoint_circle_rasterizer_core.sv @@
// Top level of the midpoint circle rasterizer: front end, point queue, pixel back end.
//
//  channel | dir | word                                     | handshake
//  i_in    | in  | kind, center_x, center_y, radius         | valid/ready
//  o_pix   | out | pixel_x, pixel_y, last_of_point, done    | valid/ready
//
// Every start or live advance word yields one point of eight pixels, one pixel per cycle while
// o_pix is ready, so the sustained rate is set by the single-pixel output register.
// The front end accepts a word per cycle while the two-entry point queue has room;
// an advance with no circle running is still taken, when the queue has room, and yields nothing.
// Synchronous active-low reset clears the step state and all valid flags.
`default_nettype none
module midpoint_circle_rasterizer_core #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcr_in_if.sink    i_in,
    mcr_pix_if.source o_pix
);
    localparam int PT_W = 4 * COORD_BITS + 1;

    logic            pt_in_valid;
    logic            pt_in_ready;
    logic [PT_W-1:0] pt_in_data;
    logic            pt_out_valid;
    logic            pt_out_ready;
    logic [PT_W-1:0] pt_out_data;

    mcr_front #(
        .COORD_BITS (COORD_BITS),
        .PT_W       (PT_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_pt_valid (pt_in_valid),
        .i_pt_ready (pt_in_ready),
        .o_pt_data  (pt_in_data)
    );

    mcr_queue #(
        .DATA_W (PT_W),
        .DEPTH  (mcr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (pt_in_valid),
        .o_push_ready (pt_in_ready),
        .i_push_data  (pt_in_data),
        .o_pop_valid  (pt_out_valid),
        .i_pop_ready  (pt_out_ready),
        .o_pop_data   (pt_out_data)
    );

    mcr_back #(
        .COORD_BITS (COORD_BITS),
        .PT_W       (PT_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt_valid (pt_out_valid),
        .o_pt_ready (pt_out_ready),
        .i_pt_data  (pt_out_data),
        .o_pix      (o_pix)
    );

endmodule
`default_nettype wire

@@ bench/circle_pixel_checker.sv @@
// Pixel checker: predicts each point from command words and compares pixel words.
`timescale 1ns / 100ps
module circle_pixel_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mcr_in_if    i_cmd,
    mcr_pix_if   i_pix,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_pixels,
    output int   o_circles
);

    localparam int CW = mcr_pkg::COORD_BITS_DEF;
    localparam int PW = CW + 2;
    localparam int DW = CW + 4;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic                 last;
        logic                 done;
    } t_pixel;

    t_pixel expected_pixels[$];

    logic        [CW-1:0] cur_x;
    logic signed [CW-1:0] cur_y;
    logic signed [DW-1:0] dec;
    logic        [CW-1:0] org_x;
    logic        [CW-1:0] org_y;
    bit                   running;

    task automatic push_pixel(input int px, input int py, input bit last, input bit done);
        t_pixel p;
        p.x    = PW'(px);
        p.y    = PW'(py);
        p.last = last;
        p.done = done;
        expected_pixels.push_back(p);
    endtask

    // eight-way mirror, fixed output order
    task automatic queue_point(input bit done);
        int cx, cy, x, y;
        cx = int'(org_x);
        cy = int'(org_y);
        x  = int'(cur_x);
        y  = int'(cur_y);
        push_pixel(cx + x, cy - y, 1'b0, done);
        push_pixel(cx + x, cy + y, 1'b0, done);
        push_pixel(cx - x, cy - y, 1'b0, done);
        push_pixel(cx - x, cy + y, 1'b0, done);
        push_pixel(cx + y, cy + x, 1'b0, done);
        push_pixel(cx + y, cy - x, 1'b0, done);
        push_pixel(cx - y, cy - x, 1'b0, done);
        push_pixel(cx - y, cy + x, 1'b1, done);
    endtask

    task automatic rasterize_word(input logic kind, input logic [CW-1:0] cx,
                                  input logic [CW-1:0] cy, input logic [CW-2:0] r);
        int x, y, d;
        if (kind == mcr_pkg::KIND_START) begin
            org_x   = cx;
            org_y   = cy;
            cur_x   = '0;
            cur_y   = CW'(int'(r));
            dec     = DW'(mcr_pkg::DEC_INIT - 2 * int'(r));
            running = 1'b1;
            queue_point(1'b0);
        end else begin
            x = int'(cur_x);
            y = int'(cur_y);
            d = int'(dec);
            if (!running || x > y) begin
                running = 1'b0;
            end else begin
                if (d < 0) begin
                    d = d + 4 * x + mcr_pkg::DEC_INC_STRAIGHT;
                end else begin
                    d = d + 4 * (x - y) + mcr_pkg::DEC_INC_DIAG;
                    y = y - 1;
                end
                x     = x + 1;
                cur_x = CW'(x);
                cur_y = CW'(y);
                dec   = DW'(d);
                if (int'(cur_x) > int'(cur_y)) begin
                    running = 1'b0;
                end
                queue_point(int'(cur_x) > int'(cur_y));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            expected_pixels.delete();
            cur_x        = '0;
            cur_y        = '0;
            dec          = '0;
            org_x        = '0;
            org_y        = '0;
            running      = 1'b0;
            o_fail_count = 0;
            o_pixels     = 0;
            o_circles    = 0;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                o_pixels = o_pixels + 1;
                if (i_pix.last_of_point === 1'b1 && i_pix.circle_done === 1'b1) begin
                    o_circles = o_circles + 1;
                end
                if (expected_pixels.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("pixel %0d: none expected, got (%0d,%0d) last=%0b done=%0b",
                                 o_pixels, i_pix.pixel_x, i_pix.pixel_y,
                                 i_pix.last_of_point, i_pix.circle_done);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pix.pixel_x !== want.x || i_pix.pixel_y !== want.y ||
                        i_pix.last_of_point !== want.last ||
                        i_pix.circle_done !== want.done) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("pixel %0d: expected (%0d,%0d) last=%0b done=%0b,",
                                     o_pixels, want.x, want.y, want.last, want.done,
                                     " got (%0d,%0d) last=%0b done=%0b",
                                     i_pix.pixel_x, i_pix.pixel_y,
                                     i_pix.last_of_point, i_pix.circle_done);
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                rasterize_word(i_cmd.kind, i_cmd.center_x, i_cmd.center_y, i_cmd.radius);
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

@@ bench/midpoint_circle_rasterizer_core_tb.sv @@
// Testbench top: clock, reset, command stimulus, pixel sink and verdict.
`timescale 1ns / 100ps
module midpoint_circle_rasterizer_core_tb;

    localparam int CW           = mcr_pkg::COORD_BITS_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASE_WORDS  = 80;
    localparam int SMALL_R_MAX  = 24;

    logic clk;
    logic rst_n;

    int sender_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int words_sent;
    int starts_sent;
    int cycle_count;

    int fail_count;
    int pending;
    int pixels_seen;
    int circles_seen;

    mcr_in_if  cmd_bus ();
    mcr_pix_if pix_bus ();

    midpoint_circle_rasterizer_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_bus),
        .o_pix   (pix_bus)
    );

    circle_pixel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_bus),
        .i_pix        (pix_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pixels     (pixels_seen),
        .o_circles    (circles_seen)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d pixels outstanding", cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // pixel sink: random stalls plus one long hold-off
    initial begin : pixel_sink
        int  hold_left;
        bit  hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        pix_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                pix_bus.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                pix_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input mcr_pkg::t_kind kind, input logic [CW-1:0] cx,
                             input logic [CW-1:0] cy, input logic [CW-2:0] r);
        while ($urandom_range(99) < sender_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.kind     <= kind;
        cmd_bus.center_x <= cx;
        cmd_bus.center_y <= cy;
        cmd_bus.radius   <= r;
        do @(posedge clk); while (cmd_bus.ready !== 1'b1);
        @(negedge clk);
        words_sent = words_sent + 1;
        if (kind == mcr_pkg::KIND_START) begin
            starts_sent = starts_sent + 1;
        end
    endtask

    task automatic advance(input int n);
        repeat (n) begin
            send_word(mcr_pkg::KIND_ADVANCE, CW'($urandom), CW'($urandom), (CW-1)'($urandom));
        end
    endtask

    // mostly complete small circles, some cut short or large and interrupted
    task automatic random_circle();
        int r, full, n;
        if ($urandom_range(99) < 85) begin
            r = $urandom_range(SMALL_R_MAX, 0);
        end else begin
            r = $urandom_range((1 << (CW - 1)) - 1, 0);
        end
        full = (r * 3) / 4 + 2;
        if (r > SMALL_R_MAX) begin
            n = $urandom_range(12, 1);
        end else if ($urandom_range(99) < 20) begin
            n = $urandom_range(full, 0);
        end else begin
            n = full;
        end
        send_word(mcr_pkg::KIND_START, CW'($urandom), CW'($urandom), (CW-1)'(r));
        advance(n);
    endtask

    initial begin : stimulus
        int goal;
        cmd_bus.valid    = 1'b0;
        cmd_bus.kind     = mcr_pkg::KIND_START;
        cmd_bus.center_x = '0;
        cmd_bus.center_y = '0;
        cmd_bus.radius   = '0;
        rst_n            = 1'b0;
        sender_idle_pct  = 0;
        recv_stall_pct   = 0;
        hold_request     = 1'b0;
        words_sent       = 0;
        starts_sent      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // advance with no circle running
        advance(1);
        // zero radius: one step to y = -1, then ignored
        send_word(mcr_pkg::KIND_START, '0, '0, '0);
        advance(2);
        // extreme center and radius, then restart mid-circle
        send_word(mcr_pkg::KIND_START, '1, '1, '1);
        advance(3);
        send_word(mcr_pkg::KIND_START, '0, '0, '1);
        advance(2);
        send_word(mcr_pkg::KIND_START, '1, '0, (CW-1)'(1));
        advance(3);
        send_word(mcr_pkg::KIND_START, '0, '1, (CW-1)'(2));
        advance(3);
        send_word(mcr_pkg::KIND_START, CW'(512), CW'(512), (CW-1)'(255));
        advance(2);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    hold_request    = 1'b1;
                end
                1: begin
                    sender_idle_pct = 70;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 70;
                end
                default: begin
                    sender_idle_pct = 30;
                    recv_stall_pct  = 30;
                end
            endcase
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal) begin
                random_circle();
            end
        end

        cmd_bus.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d command words (%0d circle starts) under four idle/stall mixes.",
                 words_sent, starts_sent);
        $display("Checked %0d pixels; %0d circles ran to completion.", pixels_seen, circles_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
